FILE: hw/rtl/jsu_pkg.sv
package jsu_pkg;

   localparam int BYTE_W = 8;
   localparam int KIND_W = 2;
   localparam int ERR_W = 3;
   localparam int CP_W = 21;
   localparam int MAX_DATA = 4;
   localparam int MAX_RESULTS = MAX_DATA + 1;
   localparam int NDATA_W = $clog2(MAX_DATA + 1);
   localparam int IDX_W = $clog2(MAX_RESULTS);

   // queue depth must be a power of two
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [KIND_W-1:0] KIND_DATA = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CLOSE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

   localparam logic [ERR_W-1:0] ERR_NONE = 3'd0;
   localparam logic [ERR_W-1:0] ERR_CONTROL = 3'd1;
   localparam logic [ERR_W-1:0] ERR_INCOMPLETE = 3'd2;
   localparam logic [ERR_W-1:0] ERR_INVALID = 3'd3;
   localparam logic [ERR_W-1:0] ERR_SURROGATE = 3'd4;
   localparam logic [ERR_W-1:0] ERR_NUL = 3'd5;
   localparam logic [ERR_W-1:0] ERR_UNCLOSED = 3'd6;

   localparam logic [BYTE_W-1:0] CHR_QUOTE = 8'h22;
   localparam logic [BYTE_W-1:0] CHR_BSLASH = 8'h5c;
   localparam logic [BYTE_W-1:0] CHR_SLASH = 8'h2f;
   localparam logic [BYTE_W-1:0] CHR_B = 8'h62;
   localparam logic [BYTE_W-1:0] CHR_F = 8'h66;
   localparam logic [BYTE_W-1:0] CHR_N = 8'h6e;
   localparam logic [BYTE_W-1:0] CHR_R = 8'h72;
   localparam logic [BYTE_W-1:0] CHR_T = 8'h74;
   localparam logic [BYTE_W-1:0] CHR_U = 8'h75;
   localparam logic [BYTE_W-1:0] CHR_SPACE = 8'h20;

   localparam logic [15:0] HIGH_FIRST = 16'hd800;
   localparam logic [15:0] HIGH_LAST = 16'hdbff;
   localparam logic [15:0] LOW_FIRST = 16'hdc00;
   localparam logic [15:0] LOW_LAST = 16'hdfff;
   localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;

   typedef enum logic [5:0] {
      MODE_NORMAL  = 6'b000001,
      MODE_ESC     = 6'b000010,
      MODE_HEX_HI  = 6'b000100,
      MODE_WANT_BS = 6'b001000,
      MODE_WANT_U  = 6'b010000,
      MODE_HEX_LO  = 6'b100000
   } mode_type;

   typedef enum logic [1:0] {
      TAIL_NONE  = 2'd0,
      TAIL_CLOSE = 2'd1,
      TAIL_ERROR = 2'd2
   } tail_type;

   typedef struct packed {
      logic [MAX_DATA-1:0][BYTE_W-1:0] data;
      logic [NDATA_W-1:0]              n_data;
      tail_type                        tail;
      logic [ERR_W-1:0]                err;
   } pkt_type;

   typedef struct packed {
      logic [MAX_DATA-1:0][BYTE_W-1:0] data;
      logic [NDATA_W-1:0]              n_data;
   } utf8_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_type;

   function automatic hex_type hex_value(input logic [BYTE_W-1:0] c);
      hex_type h;
      h.valid = 1'b1;
      h.value = c[3:0];
      if (c inside {[8'h30:8'h39]}) begin
         h.value = c[3:0];
      end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
         h.value = c[3:0] + 4'd9;
      end else begin
         h.valid = 1'b0;
      end
      return h;
   endfunction

   function automatic utf8_type utf8_encode(input logic [CP_W-1:0] v);
      utf8_type u;
      u.data = '0;
      if (v < 21'd128) begin
         u.data[0] = v[7:0];
         u.n_data = NDATA_W'(1);
      end else if (v < 21'd2048) begin
         u.data[0] = {3'b110, v[10:6]};
         u.data[1] = {2'b10, v[5:0]};
         u.n_data = NDATA_W'(2);
      end else if (v < SUPP_BASE) begin
         u.data[0] = {4'b1110, v[15:12]};
         u.data[1] = {2'b10, v[11:6]};
         u.data[2] = {2'b10, v[5:0]};
         u.n_data = NDATA_W'(3);
      end else begin
         u.data[0] = {5'b11110, v[20:18]};
         u.data[1] = {2'b10, v[17:12]};
         u.data[2] = {2'b10, v[11:6]};
         u.data[3] = {2'b10, v[5:0]};
         u.n_data = NDATA_W'(4);
      end
      return u;
   endfunction

endpackage

FILE: hw/rtl/jsu_if.sv
interface jsu_req_if;
   logic                        valid;
   logic                        ready;
   logic [jsu_pkg::BYTE_W-1:0]  in_byte;
   logic                        source_ends;

   modport source (output valid, in_byte, source_ends, input ready);
   modport sink (input valid, in_byte, source_ends, output ready);
endinterface

interface jsu_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [jsu_pkg::BYTE_W-1:0]  out_byte;
   logic [jsu_pkg::KIND_W-1:0]  kind;
   logic [jsu_pkg::ERR_W-1:0]   error_code;
   logic                        last;

   modport source (output valid, out_byte, kind, error_code, last, input ready);
   modport sink (input valid, out_byte, kind, error_code, last, output ready);
endinterface

FILE: hw/rtl/json_string_unescaper_core.sv
// a result passes through the packet queue and then the output stage register
// throughput: one request per cycle while each request yields at most one result and results are taken
// a request yielding several results holds the output until all are taken; the two-entry
// packet queue then fills and stalls the request side
// reset: synchronous, active high; clears decoder mode, queue and output stage
module json_string_unescaper_core (
   input  logic   clock,
   input  logic   reset,
   jsu_req_if.sink    req_bus,
   jsu_rsp_if.source  rsp_bus
);

   logic              push_valid;
   logic              push_ready;
   jsu_pkg::pkt_type  push_data;
   logic              pop_valid;
   logic              pop_ready;
   jsu_pkg::pkt_type  pop_data;

   jsu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready)
   );

   jsu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready)
   );

   jsu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .pop_ready (pop_ready),
      .rsp_bus   (rsp_bus)
   );

endmodule

FILE: hw/rtl/jsu_front.sv
module jsu_front (
   input  logic              clock,
   input  logic              reset,
   jsu_req_if.sink           req_bus,
   output logic              push_valid,
   output jsu_pkg::pkt_type  push_data,
   input  logic              push_ready
);

   jsu_pkg::mode_type mode_ff, mode_in;
   logic [15:0] accum_ff, accum_in;
   logic [9:0]  high_ff, high_in;
   logic [1:0]  count_ff, count_in;

   logic                        accept;
   logic [jsu_pkg::BYTE_W-1:0]  b;
   jsu_pkg::hex_type            hv;
   logic [15:0]                 acc_new;
   logic [jsu_pkg::ERR_W-1:0]   err;
   logic                        closed;
   logic                        emit_byte;
   logic [jsu_pkg::BYTE_W-1:0]  one_byte;
   logic                        emit_cp;
   logic [jsu_pkg::CP_W-1:0]    cp;
   jsu_pkg::utf8_type           enc;
   jsu_pkg::pkt_type            pkt;

   assign b = req_bus.in_byte;
   assign hv = jsu_pkg::hex_value(b);
   assign acc_new = {accum_ff[11:0], hv.value};
   assign accept = req_bus.valid && req_bus.ready;
   assign req_bus.ready = push_ready;

   always_comb begin
      mode_in = mode_ff;
      accum_in = accum_ff;
      high_in = high_ff;
      count_in = count_ff;
      err = jsu_pkg::ERR_NONE;
      closed = 1'b0;
      emit_byte = 1'b0;
      one_byte = b;
      emit_cp = 1'b0;
      cp = '0;
      case (mode_ff)
         jsu_pkg::MODE_ESC: begin
            mode_in = jsu_pkg::MODE_NORMAL;
            emit_byte = 1'b1;
            case (b)
               jsu_pkg::CHR_QUOTE, jsu_pkg::CHR_BSLASH, jsu_pkg::CHR_SLASH: one_byte = b;
               jsu_pkg::CHR_B: one_byte = 8'd8;
               jsu_pkg::CHR_F: one_byte = 8'd12;
               jsu_pkg::CHR_N: one_byte = 8'd10;
               jsu_pkg::CHR_R: one_byte = 8'd13;
               jsu_pkg::CHR_T: one_byte = 8'd9;
               jsu_pkg::CHR_U: begin
                  emit_byte = 1'b0;
                  mode_in = jsu_pkg::MODE_HEX_HI;
                  accum_in = '0;
                  count_in = '0;
               end
               default: begin
                  emit_byte = 1'b0;
                  err = jsu_pkg::ERR_INVALID;
               end
            endcase
         end
         jsu_pkg::MODE_HEX_HI, jsu_pkg::MODE_HEX_LO: begin
            if (!hv.valid) begin
               err = jsu_pkg::ERR_INVALID;
            end else if (count_ff != 2'd3) begin
               accum_in = acc_new;
               count_in = count_ff + 2'd1;
            end else begin
               accum_in = acc_new;
               count_in = '0;
               if (mode_ff == jsu_pkg::MODE_HEX_HI) begin
                  if (acc_new inside {[jsu_pkg::HIGH_FIRST:jsu_pkg::HIGH_LAST]}) begin
                     high_in = acc_new[9:0];
                     mode_in = jsu_pkg::MODE_WANT_BS;
                  end else if (acc_new inside {[jsu_pkg::LOW_FIRST:jsu_pkg::LOW_LAST]}) begin
                     err = jsu_pkg::ERR_SURROGATE;
                  end else if (acc_new == 16'd0) begin
                     err = jsu_pkg::ERR_NUL;
                  end else begin
                     emit_cp = 1'b1;
                     cp = {5'd0, acc_new};
                     mode_in = jsu_pkg::MODE_NORMAL;
                  end
               end else begin
                  if (!(acc_new inside {[jsu_pkg::LOW_FIRST:jsu_pkg::LOW_LAST]})) begin
                     err = jsu_pkg::ERR_SURROGATE;
                  end else begin
                     emit_cp = 1'b1;
                     cp = jsu_pkg::SUPP_BASE + {1'b0, high_ff, acc_new[9:0]};
                     mode_in = jsu_pkg::MODE_NORMAL;
                  end
               end
            end
         end
         jsu_pkg::MODE_WANT_BS: begin
            if (b == jsu_pkg::CHR_BSLASH) begin
               mode_in = jsu_pkg::MODE_WANT_U;
            end else begin
               err = jsu_pkg::ERR_SURROGATE;
            end
         end
         jsu_pkg::MODE_WANT_U: begin
            if (b == jsu_pkg::CHR_U) begin
               mode_in = jsu_pkg::MODE_HEX_LO;
               accum_in = '0;
               count_in = '0;
            end else begin
               err = jsu_pkg::ERR_SURROGATE;
            end
         end
         default: begin
            mode_in = jsu_pkg::MODE_NORMAL;
            if (b == jsu_pkg::CHR_QUOTE) begin
               closed = 1'b1;
            end else if (b < jsu_pkg::CHR_SPACE) begin
               err = jsu_pkg::ERR_CONTROL;
            end else if (b == jsu_pkg::CHR_BSLASH) begin
               mode_in = jsu_pkg::MODE_ESC;
            end else begin
               emit_byte = 1'b1;
            end
         end
      endcase

      // source ran out before the string closed
      if (err == jsu_pkg::ERR_NONE && !closed && req_bus.source_ends) begin
         case (mode_in)
            jsu_pkg::MODE_ESC, jsu_pkg::MODE_HEX_HI, jsu_pkg::MODE_HEX_LO:
               err = jsu_pkg::ERR_INCOMPLETE;
            jsu_pkg::MODE_WANT_BS, jsu_pkg::MODE_WANT_U:
               err = jsu_pkg::ERR_SURROGATE;
            default: err = jsu_pkg::ERR_UNCLOSED;
         endcase
      end

      if (err != jsu_pkg::ERR_NONE || closed) begin
         mode_in = jsu_pkg::MODE_NORMAL;
         accum_in = '0;
         high_in = '0;
         count_in = '0;
      end
   end

   assign enc = jsu_pkg::utf8_encode(cp);

   always_comb begin
      pkt.data = '0;
      pkt.n_data = '0;
      if (emit_cp) begin
         pkt.data = enc.data;
         pkt.n_data = enc.n_data;
      end else if (emit_byte) begin
         pkt.data[0] = one_byte;
         pkt.n_data = jsu_pkg::NDATA_W'(1);
      end
      pkt.err = err;
      if (err != jsu_pkg::ERR_NONE) begin
         pkt.tail = jsu_pkg::TAIL_ERROR;
      end else if (closed) begin
         pkt.tail = jsu_pkg::TAIL_CLOSE;
      end else begin
         pkt.tail = jsu_pkg::TAIL_NONE;
      end
   end

   assign push_data = pkt;
   assign push_valid = accept && (pkt.n_data != '0 || pkt.tail != jsu_pkg::TAIL_NONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= jsu_pkg::MODE_NORMAL;
         accum_ff <= '0;
         high_ff <= '0;
         count_ff <= '0;
      end else if (accept) begin
         mode_ff <= mode_in;
         accum_ff <= accum_in;
         high_ff <= high_in;
         count_ff <= count_in;
      end
   end

endmodule

FILE: hw/rtl/jsu_queue.sv
module jsu_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  jsu_pkg::pkt_type  push_data,
   output logic              push_ready,
   output logic              pop_valid,
   output jsu_pkg::pkt_type  pop_data,
   input  logic              pop_ready
);

   jsu_pkg::pkt_type entries_ff [jsu_pkg::QUEUE_DEPTH];
   logic [jsu_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [jsu_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [jsu_pkg::QCNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign push_ready = count_ff != jsu_pkg::QCNT_W'(jsu_pkg::QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_data = entries_ff[rd_ptr_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + jsu_pkg::QPTR_W'(do_push);
      rd_ptr_in = rd_ptr_ff + jsu_pkg::QPTR_W'(do_pop);
      count_in = count_ff + jsu_pkg::QCNT_W'(do_push) - jsu_pkg::QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hw/rtl/jsu_back.sv
module jsu_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   input  jsu_pkg::pkt_type  pop_data,
   output logic              pop_ready,
   jsu_rsp_if.source         rsp_bus
);

   jsu_pkg::pkt_type cur_ff, cur_in;
   logic cur_valid_ff, cur_valid_in;
   logic [jsu_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic [jsu_pkg::IDX_W-1:0] total;
   logic is_data, is_last, fire;

   assign total = jsu_pkg::IDX_W'(cur_ff.n_data)
                + jsu_pkg::IDX_W'(cur_ff.tail != jsu_pkg::TAIL_NONE);
   assign is_data = idx_ff < jsu_pkg::IDX_W'(cur_ff.n_data);
   assign is_last = idx_ff == total - jsu_pkg::IDX_W'(1);
   assign fire = rsp_bus.valid && rsp_bus.ready;
   assign pop_ready = !cur_valid_ff || (fire && is_last);

   always_comb begin
      rsp_bus.valid = cur_valid_ff;
      rsp_bus.last = is_last;
      if (is_data) begin
         rsp_bus.out_byte = cur_ff.data[idx_ff[1:0]];
         rsp_bus.kind = jsu_pkg::KIND_DATA;
         rsp_bus.error_code = jsu_pkg::ERR_NONE;
      end else begin
         rsp_bus.out_byte = '0;
         if (cur_ff.tail == jsu_pkg::TAIL_ERROR) begin
            rsp_bus.kind = jsu_pkg::KIND_ERROR;
            rsp_bus.error_code = cur_ff.err;
         end else begin
            rsp_bus.kind = jsu_pkg::KIND_CLOSE;
            rsp_bus.error_code = jsu_pkg::ERR_NONE;
         end
      end
   end

   always_comb begin
      cur_in = cur_ff;
      cur_valid_in = cur_valid_ff;
      idx_in = idx_ff;
      if (pop_valid && pop_ready) begin
         cur_in = pop_data;
         cur_valid_in = 1'b1;
         idx_in = '0;
      end else if (fire) begin
         if (is_last) begin
            cur_valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + jsu_pkg::IDX_W'(1);
         end
      end else if (pop_ready) begin
         cur_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

`ifndef SYNTHESIS
   a_no_empty_packet: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> (cur_ff.n_data != '0 || cur_ff.tail != jsu_pkg::TAIL_NONE))
      else $error("empty packet in output stage");
   a_data_bound: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> cur_ff.n_data <= jsu_pkg::NDATA_W'(jsu_pkg::MAX_DATA))
      else $error("too many data bytes in packet");
   a_stall_holds_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.ready |=> rsp_bus.valid && $stable(idx_ff))
      else $error("result index moved while stalled");
   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.kind != jsu_pkg::KIND_DATA |-> rsp_bus.last)
      else $error("close or error result not marked last");
`endif

endmodule

FILE: tb/tb_top.sv
module tb_top;
   import jsu_pkg::*;

   localparam int ITEM_TARGET    = 410;
   localparam int TAIL_ITEMS     = 60;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 10;

   localparam logic [BYTE_W-1:0] BYTE_BACKSPACE = 8'h08;
   localparam logic [BYTE_W-1:0] BYTE_FORMFEED  = 8'h0c;
   localparam logic [BYTE_W-1:0] BYTE_NEWLINE   = 8'h0a;
   localparam logic [BYTE_W-1:0] BYTE_RETURN    = 8'h0d;
   localparam logic [BYTE_W-1:0] BYTE_TAB       = 8'h09;

   localparam logic [7:0][BYTE_W-1:0] ESCAPE_LETTERS =
      {CHR_QUOTE, CHR_BSLASH, CHR_SLASH, CHR_B, CHR_F, CHR_N, CHR_R, CHR_T};

   typedef enum logic [2:0] {
      ST_TEXT,
      ST_ESC,
      ST_HEX_HIGH,
      ST_WANT_BSLASH,
      ST_WANT_U,
      ST_HEX_LOW
   } unesc_state_t;

   typedef struct packed {
      logic [BYTE_W-1:0] in_byte;
      logic              ends;
      logic              drain;
   } raw_byte_t;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic [KIND_W-1:0] kind;
      logic [ERR_W-1:0]  error_code;
      logic              last;
   } decoded_t;

   logic clock = 1'b0;
   logic reset;

   jsu_req_if req_bus ();
   jsu_rsp_if rsp_bus ();

   json_string_unescaper_core u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   raw_byte_t    raw_bytes[$];
   decoded_t     decoded_expect[$];
   decoded_t     step_results[$];

   unesc_state_t dec_mode;
   logic [15:0]  code_acc;
   logic [9:0]   high_bits;
   logic [1:0]   digit_cnt;

   logic         req_taken;
   logic         idling_on;
   logic         timed_out;
   int           send_gap;
   int           recv_stall;
   int           idle_cycles;
   int           cycle_count;
   int           accepted_count;
   int           total_items;
   int           mismatches;

   // decoder model

   function automatic void reset_decoder();
      dec_mode  = ST_TEXT;
      code_acc  = '0;
      high_bits = '0;
      digit_cnt = '0;
   endfunction

   function automatic void emit(input logic [BYTE_W-1:0] b, input logic [KIND_W-1:0] k,
                                input logic [ERR_W-1:0] e);
      step_results.push_back('{out_byte: b, kind: k, error_code: e, last: 1'b0});
   endfunction

   function automatic void emit_code_point(input logic [CP_W-1:0] cp);
      if (cp < 21'd128) begin
         emit(cp[7:0], KIND_DATA, ERR_NONE);
      end else if (cp < 21'd2048) begin
         emit({3'b110, cp[10:6]}, KIND_DATA, ERR_NONE);
         emit({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
      end else if (cp < SUPP_BASE) begin
         emit({4'b1110, cp[15:12]}, KIND_DATA, ERR_NONE);
         emit({2'b10, cp[11:6]}, KIND_DATA, ERR_NONE);
         emit({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
      end else begin
         emit({5'b11110, cp[20:18]}, KIND_DATA, ERR_NONE);
         emit({2'b10, cp[17:12]}, KIND_DATA, ERR_NONE);
         emit({2'b10, cp[11:6]}, KIND_DATA, ERR_NONE);
         emit({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
      end
   endfunction

   // bit 4 flags a valid digit
   function automatic logic [4:0] hex_nibble(input logic [BYTE_W-1:0] c);
      logic [BYTE_W-1:0] v;
      v = 8'hff;
      if (c >= "0" && c <= "9") v = c - "0";
      else if (c >= "a" && c <= "f") v = c - "a" + 8'd10;
      else if (c >= "A" && c <= "F") v = c - "A" + 8'd10;
      return (v == 8'hff) ? 5'b0 : {1'b1, v[3:0]};
   endfunction

   task automatic unescape_byte(input logic [BYTE_W-1:0] b, input logic ends);
      logic [ERR_W-1:0] err;
      logic             closed;
      logic [4:0]       hx;
      err    = ERR_NONE;
      closed = 1'b0;
      case (dec_mode)
         ST_ESC: begin
            dec_mode = ST_TEXT;
            case (b)
               CHR_QUOTE, CHR_BSLASH, CHR_SLASH: emit(b, KIND_DATA, ERR_NONE);
               CHR_B: emit(BYTE_BACKSPACE, KIND_DATA, ERR_NONE);
               CHR_F: emit(BYTE_FORMFEED, KIND_DATA, ERR_NONE);
               CHR_N: emit(BYTE_NEWLINE, KIND_DATA, ERR_NONE);
               CHR_R: emit(BYTE_RETURN, KIND_DATA, ERR_NONE);
               CHR_T: emit(BYTE_TAB, KIND_DATA, ERR_NONE);
               CHR_U: begin
                  dec_mode  = ST_HEX_HIGH;
                  code_acc  = '0;
                  digit_cnt = '0;
               end
               default: err = ERR_INVALID;
            endcase
         end
         ST_HEX_HIGH, ST_HEX_LOW: begin
            hx = hex_nibble(b);
            if (!hx[4]) begin
               err = ERR_INVALID;
            end else begin
               code_acc = {code_acc[11:0], hx[3:0]};
               if (digit_cnt != 2'd3) begin
                  digit_cnt = digit_cnt + 2'd1;
               end else begin
                  digit_cnt = '0;
                  if (dec_mode == ST_HEX_HIGH) begin
                     if (code_acc >= HIGH_FIRST && code_acc <= HIGH_LAST) begin
                        high_bits = code_acc[9:0];
                        dec_mode  = ST_WANT_BSLASH;
                     end else if (code_acc >= LOW_FIRST && code_acc <= LOW_LAST) begin
                        err = ERR_SURROGATE;
                     end else if (code_acc == 16'h0000) begin
                        err = ERR_NUL;
                     end else begin
                        emit_code_point({5'b0, code_acc});
                        dec_mode = ST_TEXT;
                     end
                  end else if (code_acc < LOW_FIRST || code_acc > LOW_LAST) begin
                     err = ERR_SURROGATE;
                  end else begin
                     emit_code_point(SUPP_BASE + {1'b0, high_bits, code_acc[9:0]});
                     dec_mode = ST_TEXT;
                  end
               end
            end
         end
         ST_WANT_BSLASH: begin
            if (b == CHR_BSLASH) dec_mode = ST_WANT_U;
            else err = ERR_SURROGATE;
         end
         ST_WANT_U: begin
            if (b == CHR_U) begin
               dec_mode  = ST_HEX_LOW;
               code_acc  = '0;
               digit_cnt = '0;
            end else begin
               err = ERR_SURROGATE;
            end
         end
         default: begin
            dec_mode = ST_TEXT;
            if (b == CHR_QUOTE) begin
               emit('0, KIND_CLOSE, ERR_NONE);
               closed = 1'b1;
            end else if (b < CHR_SPACE) begin
               err = ERR_CONTROL;
            end else if (b == CHR_BSLASH) begin
               dec_mode = ST_ESC;
            end else begin
               emit(b, KIND_DATA, ERR_NONE);
            end
         end
      endcase

      if (err == ERR_NONE && !closed && ends) begin
         case (dec_mode)
            ST_ESC, ST_HEX_HIGH, ST_HEX_LOW: err = ERR_INCOMPLETE;
            ST_WANT_BSLASH, ST_WANT_U:       err = ERR_SURROGATE;
            default:                         err = ERR_UNCLOSED;
         endcase
      end
      if (err != ERR_NONE) begin
         emit('0, KIND_ERROR, err);
         reset_decoder();
      end else if (closed) begin
         reset_decoder();
      end
      if (step_results.size() != 0) step_results[step_results.size() - 1].last = 1'b1;
      foreach (step_results[i]) decoded_expect.push_back(step_results[i]);
      step_results.delete();
   endtask

   // request building

   task automatic push_raw(input logic [BYTE_W-1:0] b, input logic ends = 1'b0);
      raw_bytes.push_back('{in_byte: b, ends: ends, drain: 1'b0});
   endtask

   function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) return "0" + n;
      return ($urandom_range(0, 1) ? "a" : "A") + n - 8'd10;
   endfunction

   task automatic push_escape_u(input logic [15:0] v);
      push_raw(CHR_BSLASH);
      push_raw(CHR_U);
      push_raw(hex_char(v[15:12]));
      push_raw(hex_char(v[11:8]));
      push_raw(hex_char(v[7:4]));
      push_raw(hex_char(v[3:0]));
   endtask

   task automatic push_partial_u(input int digits);
      push_raw(CHR_BSLASH);
      push_raw(CHR_U);
      repeat (digits) push_raw(hex_char(4'($urandom_range(0, 15))));
   endtask

   function automatic logic [BYTE_W-1:0] random_plain();
      logic [BYTE_W-1:0] b;
      b = 8'($urandom_range(32, 255));
      if (b == CHR_QUOTE || b == CHR_BSLASH) b = b | 8'h80;
      return b;
   endfunction

   function automatic logic [15:0] random_high();
      return 16'($urandom_range(HIGH_FIRST, HIGH_LAST));
   endfunction

   function automatic logic [15:0] random_low();
      return 16'($urandom_range(LOW_FIRST, LOW_LAST));
   endfunction

   task automatic add_random_string(input logic drain_first);
      int                first_idx;
      int                pick;
      logic [15:0]       v;
      logic [BYTE_W-1:0] b;
      logic [4:0]        hx;
      first_idx = raw_bytes.size();
      repeat ($urandom_range(1, 6)) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            push_raw(random_plain());
         end else if (pick < 55) begin
            push_raw(CHR_BSLASH);
            push_raw(ESCAPE_LETTERS[$urandom_range(0, 7)]);
         end else if (pick < 75) begin
            case ($urandom_range(0, 2))
               0:       v = 16'($urandom_range(1, 127));
               1:       v = 16'($urandom_range(128, 2047));
               default: v = 16'($urandom_range(2048, 16'hffff));
            endcase
            if (v >= HIGH_FIRST && v <= LOW_LAST) v = v ^ 16'h2000;
            push_escape_u(v);
         end else if (pick < 88) begin
            push_escape_u(random_high());
            push_escape_u(random_low());
         end else begin
            case ($urandom_range(0, 7))
               0: push_raw(8'($urandom_range(0, 31)));
               1: begin
                  b = 8'($urandom_range(0, 255));
                  if (b inside {CHR_QUOTE, CHR_BSLASH, CHR_SLASH, CHR_B, CHR_F,
                                CHR_N, CHR_R, CHR_T, CHR_U}) b = "x";
                  push_raw(CHR_BSLASH);
                  push_raw(b);
               end
               2: begin
                  b  = 8'($urandom_range(0, 255));
                  hx = hex_nibble(b);
                  if (hx[4]) b = "G";
                  push_partial_u($urandom_range(0, 3));
                  push_raw(b);
               end
               3: push_escape_u(random_low());
               4: begin
                  b = 8'($urandom_range(0, 255));
                  if (b == CHR_BSLASH) b = CHR_U;
                  push_escape_u(random_high());
                  push_raw(b);
               end
               5: begin
                  b = 8'($urandom_range(0, 255));
                  if (b == CHR_U) b = CHR_BSLASH;
                  push_escape_u(random_high());
                  push_raw(CHR_BSLASH);
                  push_raw(b);
               end
               6: begin
                  v = 16'($urandom_range(0, 16'hffff));
                  if (v >= LOW_FIRST && v <= LOW_LAST) v = v ^ 16'h4000;
                  push_escape_u(random_high());
                  push_escape_u(v);
               end
               default: push_escape_u(16'h0000);
            endcase
         end
      end

      pick = $urandom_range(0, 9);
      if (pick < 7) begin
         push_raw(CHR_QUOTE, $urandom_range(0, 3) == 0);
      end else if (pick == 7) begin
         push_raw(random_plain(), 1'b1);
      end else if (pick == 8) begin
         // source cut short in the middle of an escape
         case ($urandom_range(0, 4))
            0: push_raw(CHR_BSLASH);
            1: push_partial_u($urandom_range(0, 3));
            2: push_escape_u(random_high());
            3: begin
               push_escape_u(random_high());
               push_raw(CHR_BSLASH);
            end
            default: begin
               push_escape_u(random_high());
               push_partial_u($urandom_range(0, 3));
            end
         endcase
         raw_bytes[raw_bytes.size() - 1].ends = 1'b1;
      end

      if (raw_bytes.size() > first_idx && (drain_first || $urandom_range(0, 39) == 0))
         raw_bytes[first_idx].drain = 1'b1;
   endtask

   // request driver

   always @(negedge clock) begin
      raw_byte_t nxt;
      logic      show;
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap = 0;
      end else if (!req_bus.valid || req_taken) begin
         show = 1'b0;
         if (send_gap != 0) begin
            send_gap--;
         end else if (raw_bytes.size() != 0 &&
                      !(raw_bytes[0].drain && decoded_expect.size() != 0)) begin
            nxt  = raw_bytes.pop_front();
            show = 1'b1;
            req_bus.in_byte     <= nxt.in_byte;
            req_bus.source_ends <= nxt.ends;
            if (idling_on && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 16);
         end
         req_bus.valid <= show;
      end
      req_taken = 1'b0;
   end

   // result receiver

   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (recv_stall != 0) begin
         recv_stall--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
         if (idling_on && $urandom_range(0, 7) == 0) recv_stall = $urandom_range(1, 16);
      end
   end

   // monitor and checker

   always @(posedge clock) begin
      decoded_t got;
      decoded_t want;
      logic     rsp_taken;
      cycle_count++;
      idling_on = (raw_bytes.size() > TAIL_ITEMS) && ((cycle_count / 128) % 3 != 0);
      req_taken = !reset && req_bus.valid && req_bus.ready;
      rsp_taken = !reset && rsp_bus.valid && rsp_bus.ready;
      if (req_taken) begin
         accepted_count++;
         unescape_byte(req_bus.in_byte, req_bus.source_ends);
      end
      if (rsp_taken) begin
         got = '{out_byte: rsp_bus.out_byte, kind: rsp_bus.kind,
                 error_code: rsp_bus.error_code, last: rsp_bus.last};
         if (decoded_expect.size() == 0) begin
            $display("%0t: expected no result, actual byte=%02h kind=%0d err=%0d last=%0d",
                     $time, got.out_byte, got.kind, got.error_code, got.last);
            mismatches++;
         end else begin
            want = decoded_expect.pop_front();
            if (got != want) begin
               $display({"%0t: expected byte=%02h kind=%0d err=%0d last=%0d,",
                         " actual byte=%02h kind=%0d err=%0d last=%0d"},
                        $time, want.out_byte, want.kind, want.error_code, want.last,
                        got.out_byte, got.kind, got.error_code, got.last);
               mismatches++;
            end
         end
      end
      if (req_taken || rsp_taken) idle_cycles = 0;
      else idle_cycles++;
   end

   initial begin
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.in_byte     = '0;
      req_bus.source_ends = 1'b0;
      rsp_bus.ready       = 1'b0;
      req_taken           = 1'b0;
      idling_on           = 1'b0;
      timed_out           = 1'b0;
      send_gap            = 0;
      recv_stall          = 0;
      idle_cycles         = 0;
      cycle_count         = 0;
      accepted_count      = 0;
      mismatches          = 0;
      reset_decoder();

      // plain bytes at both ends of the range, then a close
      push_raw(CHR_SPACE);
      push_raw(8'hff);
      push_raw(CHR_QUOTE);
      // control byte
      push_raw(8'h00);
      // unknown escape letter
      push_raw(CHR_BSLASH);
      push_raw("x");
      // non-hex digit in a unicode escape
      push_partial_u(2);
      push_raw("g");
      // lone low surrogate
      push_escape_u(LOW_FIRST);
      // escaped nul
      push_escape_u(16'h0000);
      // source ends inside the string
      push_raw("A", 1'b1);

      add_random_string(1'b1);
      while (raw_bytes.size() < ITEM_TARGET) add_random_string(1'b0);
      total_items = raw_bytes.size();

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      while (!timed_out && (accepted_count != total_items || decoded_expect.size() != 0)) begin
         @(negedge clock);
         if (idle_cycles >= WATCHDOG_LIMIT) timed_out = 1'b1;
      end
      if (!timed_out) begin
         repeat (DRAIN_CYCLES) @(negedge clock);
         foreach (decoded_expect[i]) begin
            $display("%0t: expected byte=%02h kind=%0d err=%0d last=%0d, actual none",
                     $time, decoded_expect[i].out_byte, decoded_expect[i].kind,
                     decoded_expect[i].error_code, decoded_expect[i].last);
            mismatches++;
         end
      end

      if (!timed_out && mismatches == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
